### hw/rtl/stg_pkg.sv
// Shared constants and types for the stepper tone generator.
`timescale 1ns / 1ps
`default_nettype none

package stg_pkg;

   // Field widths
   localparam int ModeWidth     = 2;
   localparam int KeyWidth      = 8;
   localparam int PosWidth      = 8;
   localparam int PeriodWidth   = 31;
   localparam int LimitWidth    = 8;
   localparam int CsrIndexWidth = 1;
   localparam int ReqDataWidth  = 8;
   localparam int RspDataWidth  = 48;
   localparam int RspUsedWidth  = 1 + 1 + PosWidth + PeriodWidth + 1;

   typedef logic [PeriodWidth-1:0] period_type;
   typedef logic [PosWidth-1:0]    pos_type;

   // Register reset values
   localparam logic [LimitWidth-1:0] UpperLimitReset = 8'd153;
   localparam logic [LimitWidth-1:0] LowerLimitReset = 8'd10;

   // Register indexes
   localparam logic [CsrIndexWidth-1:0] CsrUpperLimit = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CsrLowerLimit = 1'd1;

   // Item kinds carried on req_tuser
   localparam logic [ModeWidth-1:0] ModeTick = 2'd0;
   localparam logic [ModeWidth-1:0] ModeKey  = 2'd1;
   localparam logic [ModeWidth-1:0] ModePlay = 2'd2;

   // Period limits
   localparam period_type PeriodMax  = {PeriodWidth{1'b1}};
   localparam period_type PeriodHalf = period_type'(1) << (PeriodWidth - 1);

   // Note periods in ticks
   localparam period_type NoteA = 31'd2249;
   localparam period_type NoteS = 31'd2003;
   localparam period_type NoteD = 31'd1785;
   localparam period_type NoteF = 31'd1685;
   localparam period_type NoteG = 31'd1498;
   localparam period_type NoteH = 31'd1336;
   localparam period_type NoteJ = 31'd1191;
   localparam period_type NoteK = 31'd1124;
   localparam period_type PowerZero = 31'd1024;

   // ASCII key codes
   localparam logic [KeyWidth-1:0] KeyA     = 8'h61;
   localparam logic [KeyWidth-1:0] KeyS     = 8'h73;
   localparam logic [KeyWidth-1:0] KeyD     = 8'h64;
   localparam logic [KeyWidth-1:0] KeyF     = 8'h66;
   localparam logic [KeyWidth-1:0] KeyG     = 8'h67;
   localparam logic [KeyWidth-1:0] KeyH     = 8'h68;
   localparam logic [KeyWidth-1:0] KeyJ     = 8'h6A;
   localparam logic [KeyWidth-1:0] KeyK     = 8'h6B;
   localparam logic [KeyWidth-1:0] KeyZ     = 8'h7A;
   localparam logic [KeyWidth-1:0] KeyX     = 8'h78;
   localparam logic [KeyWidth-1:0] KeySlash = 8'h2F;
   localparam logic [KeyWidth-1:0] KeyC     = 8'h63;
   localparam logic [KeyWidth-1:0] KeyStar  = 8'h2A;
   localparam logic [KeyWidth-1:0] KeyV     = 8'h76;
   localparam logic [KeyWidth-1:0] KeyPlus  = 8'h2B;
   localparam logic [KeyWidth-1:0] KeyEqual = 8'h3D;
   localparam logic [KeyWidth-1:0] KeyB     = 8'h62;
   localparam logic [KeyWidth-1:0] KeyMinus = 8'h2D;
   localparam logic [KeyWidth-1:0] KeyZero  = 8'h30;
   localparam logic [KeyWidth-1:0] KeyOne   = 8'h31;
   localparam logic [KeyWidth-1:0] KeyNine  = 8'h39;

endpackage

`default_nettype wire

### hw/rtl/stepper_tone_generator_top.sv
// Stepper tone generator: tick counter, key decoder and head sweep in one stage.
//
// Each input word is a timer tick, a key command or a play-button event, and
// every word produces exactly one result word: the step and direction lines,
// the head position, the tone period and the play flag after that word. The
// block takes one word per clock cycle unless the result register stalls it:
// the counter increment, the period compare, the key decode and the position
// update all settle combinationally between the state registers and the result
// register. The result register lets a new word in whenever the held result is
// taken in the same cycle or none is held. The user writes the limits through
// the csr_ port while the block is idle; the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module stepper_tone_generator_top
   import stg_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // Input words
   input  wire logic                     req_tvalid,
   output      logic                     req_tready,
   input  wire logic [ReqDataWidth-1:0]  req_tdata,  // key_code[7:0]
   input  wire logic [ModeWidth-1:0]     req_tuser,  // mode[1:0]
   // Result words
   output      logic                     rsp_tvalid,
   input  wire logic                     rsp_tready,
   // step_level[0], dir_level[1], position[9:2], period_now[40:10],
   // playing[41], zero fill[47:42]
   output      logic [RspDataWidth-1:0]  rsp_tdata,
   // Register writes
   input  wire logic                     csr_we,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [LimitWidth-1:0]    csr_wdata
);

   logic                  req_accept;
   logic [LimitWidth-1:0] upper_limit_ff;
   logic [LimitWidth-1:0] lower_limit_ff;
   period_type            tone_period_ff, tone_period_in;
   period_type            tick_count_ff,  tick_count_in;
   pos_type               head_pos_ff,    head_pos_in;
   logic                  moving_down_ff, moving_down_in;
   logic                  pulse_level_ff, pulse_level_in;
   logic                  play_enable_ff, play_enable_in;
   logic                  rsp_valid_ff;
   logic [RspUsedWidth-1:0] rsp_data_ff;

   period_type            tick_next;
   period_type            key_period;
   logic                  tick_live;
   logic                  do_step;
   logic                  turn_down;
   logic [3:0]            digit;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   // Limit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         upper_limit_ff <= UpperLimitReset;
         lower_limit_ff <= LowerLimitReset;
      end else if (csr_we) begin
         unique case (csr_index)
            CsrUpperLimit: upper_limit_ff <= csr_wdata;
            CsrLowerLimit: lower_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Tick counter and step decision
   assign tick_live = (req_tuser == ModeTick) && play_enable_ff && (tone_period_ff != '0);
   assign tick_next = tick_count_ff + period_type'(1);
   assign do_step   = tick_live && (tone_period_ff <= tick_next);

   // Key decoder: the new period for a key word
   assign digit = 4'(req_tdata - KeyZero);

   always_comb begin
      key_period = tone_period_ff;
      unique case (req_tdata)
         KeyA: key_period = NoteA;
         KeyS: key_period = NoteS;
         KeyD: key_period = NoteD;
         KeyF: key_period = NoteF;
         KeyG: key_period = NoteG;
         KeyH: key_period = NoteH;
         KeyJ: key_period = NoteJ;
         KeyK: key_period = NoteK;
         KeyZ: key_period = PeriodMax;
         KeyX, KeySlash: begin
            key_period = (tone_period_ff == '0) ? period_type'(1) : (tone_period_ff >> 1);
         end
         KeyC, KeyStar: begin
            key_period = (tone_period_ff >= PeriodHalf) ? PeriodMax : (tone_period_ff << 1);
         end
         KeyV, KeyPlus, KeyEqual: begin
            if (tone_period_ff != PeriodMax) key_period = tone_period_ff + period_type'(1);
         end
         KeyB, KeyMinus: begin
            if (tone_period_ff != '0) key_period = tone_period_ff - period_type'(1);
         end
         KeyZero: key_period = PowerZero;
         default: begin
            if (req_tdata >= KeyOne && req_tdata <= KeyNine) begin
               key_period = period_type'(1) << digit;
            end
         end
      endcase
   end

   // Next state for the accepted word
   assign turn_down = head_pos_ff >= upper_limit_ff;

   always_comb begin
      tone_period_in = tone_period_ff;
      tick_count_in  = tick_count_ff;
      head_pos_in    = head_pos_ff;
      moving_down_in = moving_down_ff;
      pulse_level_in = pulse_level_ff;
      play_enable_in = play_enable_ff;
      priority if (req_tuser == ModeTick) begin
         if (tick_live) tick_count_in = tick_next;
         if (do_step) begin
            tick_count_in = '0;
            if (turn_down) moving_down_in = 1'b1;
            else if (head_pos_ff <= lower_limit_ff) moving_down_in = 1'b0;
            head_pos_in    = moving_down_in ? head_pos_ff - pos_type'(1)
                                            : head_pos_ff + pos_type'(1);
            pulse_level_in = !pulse_level_ff;
         end
      end else if (req_tuser == ModeKey) begin
         tone_period_in = key_period;
      end else if (req_tuser == ModePlay) begin
         play_enable_in = !play_enable_ff;
      end else begin
         // The unused mode leaves every state register as it is.
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tone_period_ff <= '0;
         tick_count_ff  <= '0;
         head_pos_ff    <= '0;
         moving_down_ff <= 1'b0;
         pulse_level_ff <= 1'b0;
         play_enable_ff <= 1'b1;
      end else if (req_accept) begin
         tone_period_ff <= tone_period_in;
         tick_count_ff  <= tick_count_in;
         head_pos_ff    <= head_pos_in;
         moving_down_ff <= moving_down_in;
         pulse_level_ff <= pulse_level_in;
         play_enable_ff <= play_enable_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= {play_enable_in, tone_period_in, head_pos_in,
                         moving_down_in, pulse_level_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspDataWidth-RspUsedWidth){1'b0}}, rsp_data_ff};

   // Checks
   a_pos_moves_one: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> (head_pos_ff == $past(head_pos_ff)
                         || head_pos_ff == $past(head_pos_ff) + pos_type'(1)
                         || head_pos_ff == $past(head_pos_ff) - pos_type'(1)))
      else $error("head position jumped by more than one step");

   a_pulse_with_move: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> ((pulse_level_ff != $past(pulse_level_ff))
                         == (head_pos_ff != $past(head_pos_ff))))
      else $error("step line toggled without a head move or the reverse");

   a_play_toggle: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tuser == ModePlay) |=> (play_enable_ff != $past(play_enable_ff)))
      else $error("play event did not toggle the play flag");

   a_rsp_from_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_accept))
      else $error("result word appeared without an accepted input word");

endmodule

`default_nettype wire
